@@ sv/assert_macros.svh @@
// Assertion macros used by the top-level RTL file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every rising clock edge, off while reset is asserted.
`define RCR_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Condition that must never be seen.
`define RCR_NEVER(lbl, cond, msg) `RCR_ASSERT(lbl, !(cond), msg)

`endif

@@ sv/rcr_pkg.sv @@
// Shared types, constants and arithmetic steps of the coalescence rate core.
package rcr_pkg;

	// Register indexes of the configuration port.
	localparam logic [1:0] REG_COLL  = 2'd0;
	localparam logic [1:0] REG_EXPC  = 2'd1;
	localparam logic [1:0] REG_MAXP  = 2'd2;
	localparam logic [1:0] REG_SHAPE = 2'd3;

	localparam logic [15:0] MAXP_RESET = 16'hFFFF;

	// Pipeline depths.
	localparam int CBRT_STEPS     = 21;
	localparam int CBRT_TOP_SHIFT = 60;
	localparam int DIV_STEPS      = 57;
	localparam int EXP_SQUARINGS  = 10;
	localparam int EXP_STAGES     = 5 + EXP_SQUARINGS;
	localparam int GAIN_STAGES    = 7;
	localparam int DEN_DLY        = DIV_STEPS + EXP_STAGES;
	localparam int V_DLY          = 1 + CBRT_STEPS + 1 + DIV_STEPS + EXP_STAGES + DIV_STEPS
		- (1 + GAIN_STAGES);

	localparam logic [32:0] ONE_Q32 = 33'h1_0000_0000;
	localparam logic [31:0] RECIP3  = 32'hAAAA_AAAB;

	typedef struct packed {
		logic [59:0] x;
		logic [19:0] y;
	} cbrt_st_t;

	typedef struct packed {
		logic [39:0] rem;
		logic [56:0] nq;
	} div_st_t;

	typedef struct packed {
		logic        saturated;
		logic        active;
		logic [31:0] rate;
	} out_item_t;

	// One digit of the integer cube root, radix 8.
	function automatic cbrt_st_t cbrt_step(input cbrt_st_t cur, input logic [5:0] sh);
		cbrt_st_t    nxt;
		logic [19:0] y2;
		logic [42:0] b;
		logic [59:0] xs;
		y2 = {cur.y[18:0], 1'b0};
		b = 43'd3 * 43'(y2) * (43'(y2) + 43'd1) + 43'd1;
		xs = cur.x >> sh;
		nxt.x = cur.x;
		nxt.y = y2;
		if (60'(b) <= xs) begin
			nxt.x = cur.x - (60'(b) << sh);
			nxt.y = y2 + 20'd1;
		end
		return nxt;
	endfunction

	// One quotient bit of restoring division.
	function automatic div_st_t div_step(input div_st_t cur, input logic [39:0] den);
		div_st_t     nxt;
		logic [40:0] r;
		logic        qb;
		r = {cur.rem, cur.nq[56]};
		qb = 1'b0;
		if (r >= {1'b0, den}) begin
			r = r - {1'b0, den};
			qb = 1'b1;
		end
		nxt.rem = r[39:0];
		nxt.nq = {cur.nq[55:0], qb};
		return nxt;
	endfunction

	// Q0.32 product, rounded half up.
	function automatic logic [32:0] mulq(input logic [32:0] a, input logic [32:0] b);
		logic [65:0] p;
		p = 66'(a) * 66'(b) + 66'h8000_0000;
		return p[64:32];
	endfunction

endpackage

@@ sv/rcr_cbrt.sv @@
// Three-lane digit-per-stage integer cube root pipeline.
module rcr_cbrt (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        en,
	input  logic        in_valid,
	input  logic [59:0] in_xa,
	input  logic [59:0] in_xm,
	input  logic [59:0] in_xam,
	output logic        out_valid,
	output logic [19:0] out_ca,
	output logic [19:0] out_cm,
	output logic [19:0] out_cam
);
	import rcr_pkg::*;

	logic     vld_s [CBRT_STEPS];
	cbrt_st_t a_s   [CBRT_STEPS];
	cbrt_st_t m_s   [CBRT_STEPS];
	cbrt_st_t am_s  [CBRT_STEPS];

	for (genvar k = 0; k < CBRT_STEPS; k++) begin : g_stage
		cbrt_st_t a_in, m_in, am_in;
		logic     v_in;
		localparam logic [5:0] SH = 6'(CBRT_TOP_SHIFT - 3 * k);
		if (k == 0) begin : g_first
			assign a_in  = '{x: in_xa, y: 20'd0};
			assign m_in  = '{x: in_xm, y: 20'd0};
			assign am_in = '{x: in_xam, y: 20'd0};
			assign v_in  = in_valid;
		end else begin : g_next
			assign a_in  = a_s[k-1];
			assign m_in  = m_s[k-1];
			assign am_in = am_s[k-1];
			assign v_in  = vld_s[k-1];
		end
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k] <= 1'b0;
			end else if (en) begin
				vld_s[k] <= v_in;
			end
		end
		always_ff @(posedge clk) begin
			if (en) begin
				a_s[k]  <= cbrt_step(a_in, SH);
				m_s[k]  <= cbrt_step(m_in, SH);
				am_s[k] <= cbrt_step(am_in, SH);
			end
		end
	end

	assign out_valid = vld_s[CBRT_STEPS-1];
	assign out_ca    = a_s[CBRT_STEPS-1].y;
	assign out_cm    = m_s[CBRT_STEPS-1].y;
	assign out_cam   = am_s[CBRT_STEPS-1].y;

endmodule

@@ sv/rcr_div.sv @@
// Bit-per-stage restoring divider, 57-bit numerator over 40-bit divisor.
module rcr_div (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        en,
	input  logic        in_valid,
	input  logic [56:0] in_num,
	input  logic [39:0] in_den,
	output logic        out_valid,
	output logic [56:0] out_quo
);
	import rcr_pkg::*;

	logic        vld_s [DIV_STEPS];
	div_st_t     st_s  [DIV_STEPS];
	logic [39:0] den_s [DIV_STEPS];

	for (genvar k = 0; k < DIV_STEPS; k++) begin : g_stage
		div_st_t     st_in;
		logic [39:0] den_in;
		logic        v_in;
		if (k == 0) begin : g_first
			assign st_in  = '{rem: 40'd0, nq: in_num};
			assign den_in = in_den;
			assign v_in   = in_valid;
		end else begin : g_next
			assign st_in  = st_s[k-1];
			assign den_in = den_s[k-1];
			assign v_in   = vld_s[k-1];
		end
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k] <= 1'b0;
			end else if (en) begin
				vld_s[k] <= v_in;
			end
		end
		always_ff @(posedge clk) begin
			if (en) begin
				st_s[k]  <= div_step(st_in, den_in);
				den_s[k] <= den_in;
			end
		end
	end

	assign out_valid = vld_s[DIV_STEPS-1];
	assign out_quo   = st_s[DIV_STEPS-1].nq;

endmodule

@@ sv/rcr_exp.sv @@
// exp(-t) in Q0.32: Horner series on t/1024, then ten squarings.
module rcr_exp (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        en,
	input  logic        in_valid,
	input  logic [56:0] in_t,
	output logic        out_valid,
	output logic [31:0] out_e
);
	import rcr_pkg::*;

	logic        vld_s [EXP_STAGES];
	logic        lim_s1, lim_s2, lim_s3, lim_s4;
	logic [26:0] y_s1, y_s2, y_s3, y_s4;
	logic [32:0] q0_s1, q1_s3, q2_s4;
	logic [27:0] m1_s2;
	logic [31:0] sq_s [EXP_SQUARINGS + 1];

	logic [59:0] div3_p;
	logic [32:0] m1, m2, m3, q3;
	logic [32:0] sq_p [EXP_SQUARINGS];

	assign m1 = mulq(33'(y_s1), q0_s1);
	assign div3_p = 60'(m1_s2) * 60'(RECIP3);
	assign m2 = mulq(33'(y_s3), q1_s3);
	assign m3 = mulq(33'(y_s4), q2_s4);
	assign q3 = ONE_Q32 - m3;

	for (genvar g = 0; g < EXP_SQUARINGS; g++) begin : g_sq
		assign sq_p[g] = mulq(33'(sq_s[g]), 33'(sq_s[g]));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < EXP_STAGES; i++) vld_s[i] <= 1'b0;
		end else if (en) begin
			vld_s[0] <= in_valid;
			for (int i = 1; i < EXP_STAGES; i++) vld_s[i] <= vld_s[i-1];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			// t of 32.0 and above gives zero
			lim_s1 <= |in_t[56:21];
			y_s1   <= {in_t[20:0], 6'd0};
			// 1 - y/4, with y/4 = t*16
			q0_s1  <= ONE_Q32 - {8'd0, in_t[20:0], 4'd0};
			lim_s2 <= lim_s1;
			y_s2   <= y_s1;
			m1_s2  <= m1[27:0];
			lim_s3 <= lim_s2;
			y_s3   <= y_s2;
			q1_s3  <= ONE_Q32 - 33'(div3_p[59:33]);
			lim_s4 <= lim_s3;
			y_s4   <= y_s3;
			q2_s4  <= ONE_Q32 - (m2 >> 1);
			if (lim_s4) sq_s[0] <= 32'd0;
			else if (q3[32]) sq_s[0] <= 32'hFFFF_FFFF;
			else sq_s[0] <= q3[31:0];
			for (int i = 1; i <= EXP_SQUARINGS; i++)
				sq_s[i] <= sq_p[i-1][31:0];
		end
	end

	assign out_valid = vld_s[EXP_STAGES-1];
	assign out_e     = sq_s[EXP_SQUARINGS];

endmodule

@@ sv/rcr_gain.sv @@
// Product chain 12*phi*alpha*Crc*Ut*kappa, split into partial products.
module rcr_gain (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        en,
	input  logic        in_valid,
	input  logic        in_active,
	input  logic [15:0] in_alpha,
	input  logic [31:0] in_kappa,
	input  logic [23:0] in_ut,
	input  logic [23:0] shape,
	input  logic [23:0] coll,
	output logic        out_valid,
	output logic        out_active,
	output logic [59:0] out_v
);
	import rcr_pkg::*;

	logic        vld_s [GAIN_STAGES];
	logic        act_s [GAIN_STAGES];
	logic [31:0] kap_s [GAIN_STAGES-2];
	logic [23:0] ut_s  [GAIN_STAGES-4];

	logic [39:0] pa;
	logic [43:0] v0_s1;
	logic [55:0] pl_s2;
	logic [35:0] ph_s2;
	logic [51:0] v1_s3;
	logic [55:0] pl_s4;
	logic [43:0] ph_s4;
	logic [59:0] v2_s5;
	logic [63:0] pl_s6;
	logic [59:0] ph_s6;
	logic [59:0] v3_s7;

	logic [67:0] sum3;
	logic [75:0] sum5;
	logic [60:0] sum7;

	assign pa   = 40'(shape) * 40'(in_alpha);
	assign sum3 = {ph_s2, 32'd0} + 68'(pl_s2);
	assign sum5 = {ph_s4, 32'd0} + 76'(pl_s4);
	assign sum7 = 61'(ph_s6) + 61'(pl_s6[63:32]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < GAIN_STAGES; i++) vld_s[i] <= 1'b0;
		end else if (en) begin
			vld_s[0] <= in_valid;
			for (int i = 1; i < GAIN_STAGES; i++) vld_s[i] <= vld_s[i-1];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			act_s[0] <= in_active;
			kap_s[0] <= in_kappa;
			ut_s[0]  <= in_ut;
			for (int i = 1; i < GAIN_STAGES; i++) act_s[i] <= act_s[i-1];
			for (int i = 1; i < GAIN_STAGES - 2; i++) kap_s[i] <= kap_s[i-1];
			for (int i = 1; i < GAIN_STAGES - 4; i++) ut_s[i] <= ut_s[i-1];
			// x12 as x8 + x4
			v0_s1 <= {pa, 3'd0} + {2'd0, pa, 2'd0};
			pl_s2 <= 56'(v0_s1[31:0]) * 56'(coll);
			ph_s2 <= 36'(v0_s1[43:32]) * 36'(coll);
			v1_s3 <= sum3[67:16];
			pl_s4 <= 56'(v1_s3[31:0]) * 56'(ut_s[2]);
			ph_s4 <= 44'(v1_s3[51:32]) * 44'(ut_s[2]);
			v2_s5 <= sum5[75:16];
			pl_s6 <= 64'(v2_s5[31:0]) * 64'(kap_s[4]);
			ph_s6 <= 60'(v2_s5[59:32]) * 60'(kap_s[4]);
			// inactive cells carry a zero gain so their rate ends up zero
			v3_s7 <= act_s[5] ? sum7[59:0] : 60'd0;
		end
	end

	assign out_valid  = vld_s[GAIN_STAGES-1];
	assign out_active = act_s[GAIN_STAGES-1];
	assign out_v      = v3_s7;

endmodule

@@ sv/random_coalescence_rate_core.sv @@
// Top level of the random-collision coalescence rate core.
//
// Streaming kernel that takes one mesh cell per clock (phase fraction,
// interfacial area concentration, turbulent velocity) and returns one rate
// item per cell, in order. Throughput is one item per cycle while the output
// buffer has room. Each item passes the 21-stage cube root pipeline, two
// 57-stage restoring dividers (exponent argument and final quotient) and the
// 15-stage exponential. A two-entry output buffer lets new items enter while
// a result waits; the whole pipeline holds only when both entries are
// occupied. Configuration is to be written through the APB port only while
// no item is in flight; the block itself does not enforce this. Registers
// sit at byte addresses 0x0 (collision coeff), 0x4 (exp coeff), 0x8 (max
// packing), 0xC (shape factor).
`include "assert_macros.svh"

module random_coalescence_rate_core (
	input  logic        clk,
	input  logic        arst_n,
	// APB configuration port
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	// cell input: [15:0] phase_fraction, [47:16] area_density, [71:48] turb_velocity
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [71:0] s_tdata,
	// result: [31:0] coal_rate
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,
	// result flags: [0] active, [1] saturated
	output logic [1:0]  m_tuser
);
	import rcr_pkg::*;

	// ---------------- configuration registers ----------------
	logic [23:0] coll_q, expc_q, shape_q;
	logic [15:0] maxp_q;
	logic        cfg_wr;

	assign pready = 1'b1;
	assign cfg_wr = psel & penable & pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coll_q  <= 24'd0;
			expc_q  <= 24'd0;
			maxp_q  <= MAXP_RESET;
			shape_q <= 24'd0;
		end else if (cfg_wr) begin
			case (paddr[3:2])
				REG_COLL:  coll_q  <= pwdata[23:0];
				REG_EXPC:  expc_q  <= pwdata[23:0];
				REG_MAXP:  maxp_q  <= pwdata[15:0];
				REG_SHAPE: shape_q <= pwdata[23:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[3:2])
			REG_COLL:  prdata = {8'd0, coll_q};
			REG_EXPC:  prdata = {8'd0, expc_q};
			REG_MAXP:  prdata = {16'd0, maxp_q};
			REG_SHAPE: prdata = {8'd0, shape_q};
			default:   prdata = 32'd0;
		endcase
	end

	// ---------------- global pipeline enable ----------------
	// Every stage moves together; the output buffer decides.
	logic [1:0] out_cnt_q;
	logic       pipe_en;

	assign pipe_en  = (out_cnt_q != 2'd2);
	assign s_tready = pipe_en;

	// ---------------- stage 1: input register ----------------
	logic        vld_s1, act_s1;
	logic [15:0] alpha_s1;
	logic [31:0] kappa_s1;
	logic [23:0] ut_s1;
	logic [31:0] am_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (pipe_en) begin
			vld_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (pipe_en) begin
			alpha_s1 <= s_tdata[15:0];
			kappa_s1 <= s_tdata[47:16];
			ut_s1    <= s_tdata[71:48];
			am_s1    <= 32'(s_tdata[15:0]) * 32'(maxp_q);
			// rate is nonzero only for kappa > 0 and alpha below max packing
			act_s1   <= (s_tdata[47:16] != 32'd0) && (s_tdata[15:0] < maxp_q);
		end
	end

	// ---------------- cube roots, Q0.20 ----------------
	logic        cb_vld;
	logic [19:0] ca, cm, cam;

	rcr_cbrt u_cbrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (pipe_en),
		.in_valid (vld_s1),
		.in_xa    ({alpha_s1, 44'd0}),
		.in_xm    ({maxp_q, 44'd0}),
		.in_xam   ({am_s1, 28'd0}),
		.out_valid(cb_vld),
		.out_ca   (ca),
		.out_cm   (cm),
		.out_cam  (cam)
	);

	// ---------------- gain product, runs alongside ----------------
	logic        g_vld, g_act;
	logic [59:0] g_v;

	rcr_gain u_gain (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (pipe_en),
		.in_valid  (vld_s1),
		.in_active (act_s1),
		.in_alpha  (alpha_s1),
		.in_kappa  (kappa_s1),
		.in_ut     (ut_s1),
		.shape     (shape_q),
		.coll      (coll_q),
		.out_valid (g_vld),
		.out_active(g_act),
		.out_v     (g_v)
	);

	// ---------------- stage 23: root difference and products ----------------
	logic        vld_s23;
	logic [19:0] d_s23;
	logic [43:0] numt_s23;
	logic [39:0] denh_s23;
	logic [19:0] d_raw, d_fix;

	assign d_raw = cm - ca;
	// equal roots only occur for inactive cells; keep the divisor nonzero
	assign d_fix = (d_raw == 20'd0) ? 20'd1 : d_raw;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s23 <= 1'b0;
		end else if (pipe_en) begin
			vld_s23 <= cb_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (pipe_en) begin
			d_s23    <= d_fix;
			numt_s23 <= 44'(expc_q) * 44'(cam);
			denh_s23 <= 40'(cm) * 40'(d_fix);
		end
	end

	// ---------------- exponent argument t = C*cam/d ----------------
	logic        t_vld;
	logic [56:0] t_q16;

	rcr_div u_div_t (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (pipe_en),
		.in_valid (vld_s23),
		.in_num   ({13'd0, numt_s23}),
		.in_den   ({20'd0, d_s23}),
		.out_valid(t_vld),
		.out_quo  (t_q16)
	);

	// ---------------- exp(-t) ----------------
	logic        e_vld;
	logic [31:0] e_q32;

	rcr_exp u_exp (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (pipe_en),
		.in_valid (t_vld),
		.in_t     (t_q16),
		.out_valid(e_vld),
		.out_e    (e_q32)
	);

	// cm*d waits for the exponential
	logic [39:0] denh_dly_q [DEN_DLY];

	always_ff @(posedge clk) begin
		if (pipe_en) begin
			denh_dly_q[0] <= denh_s23;
			for (int i = 1; i < DEN_DLY; i++) denh_dly_q[i] <= denh_dly_q[i-1];
		end
	end

	// ---------------- h = ((1 - e) << 24) / (cm*d) ----------------
	logic [32:0] f_q32;
	logic        h_vld;
	logic [56:0] h_q16;

	assign f_q32 = ONE_Q32 - {1'b0, e_q32};

	rcr_div u_div_h (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (pipe_en),
		.in_valid (e_vld),
		.in_num   ({f_q32, 24'd0}),
		.in_den   (denh_dly_q[DEN_DLY-1]),
		.out_valid(h_vld),
		.out_quo  (h_q16)
	);

	// gain and active flag wait for h
	logic [59:0] v_dly_q   [V_DLY];
	logic        act_dly_q [V_DLY];

	always_ff @(posedge clk) begin
		if (pipe_en) begin
			v_dly_q[0]   <= g_v;
			act_dly_q[0] <= g_vld & g_act;
			for (int i = 1; i < V_DLY; i++) begin
				v_dly_q[i]   <= v_dly_q[i-1];
				act_dly_q[i] <= act_dly_q[i-1];
			end
		end
	end

	// ---------------- final product v*h, 30-bit partials ----------------
	logic        vld_s153, act_s153, vld_s154, act_s154;
	logic [59:0] p0_s153, p2_s153, p0_s154;
	logic [56:0] p1_s153, p3_s153, p3_s154;
	logic [60:0] mid_s154;
	logic [59:0] v_fin;

	assign v_fin = v_dly_q[V_DLY-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s153 <= 1'b0;
			vld_s154 <= 1'b0;
		end else if (pipe_en) begin
			vld_s153 <= h_vld;
			vld_s154 <= vld_s153;
		end
	end

	always_ff @(posedge clk) begin
		if (pipe_en) begin
			act_s153 <= act_dly_q[V_DLY-1];
			p0_s153  <= 60'(v_fin[29:0]) * 60'(h_q16[29:0]);
			p1_s153  <= 57'(v_fin[29:0]) * 57'(h_q16[56:30]);
			p2_s153  <= 60'(v_fin[59:30]) * 60'(h_q16[29:0]);
			p3_s153  <= 57'(v_fin[59:30]) * 57'(h_q16[56:30]);
			act_s154 <= act_s153;
			p0_s154  <= p0_s153;
			p3_s154  <= p3_s153;
			mid_s154 <= 61'(p1_s153) + 61'(p2_s153);
		end
	end

	// Q24.8 rate is product >> 24; anything at or above bit 56 clips.
	logic [116:0] prod;
	out_item_t    res;

	assign prod = 117'(p0_s154) + (117'(mid_s154) << 30) + (117'(p3_s154) << 60);

	always_comb begin
		res.active    = act_s154;
		res.saturated = |prod[116:56];
		res.rate      = res.saturated ? 32'hFFFF_FFFF : prod[55:24];
	end

	// ---------------- two-entry output buffer ----------------
	out_item_t slot0_q, slot1_q;
	logic      push, pop;

	assign push = vld_s154 & pipe_en;
	assign pop  = m_tvalid & m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_cnt_q <= 2'd0;
		end else begin
			case ({push, pop})
				2'b10:   out_cnt_q <= out_cnt_q + 2'd1;
				2'b01:   out_cnt_q <= out_cnt_q - 2'd1;
				default: out_cnt_q <= out_cnt_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			slot0_q <= (out_cnt_q == 2'd1) ? res : slot1_q;
		end else if (push) begin
			if (out_cnt_q == 2'd0) slot0_q <= res;
			else slot1_q <= res;
		end
	end

	assign m_tvalid = (out_cnt_q != 2'd0);
	assign m_tdata  = slot0_q.rate;
	assign m_tuser  = {slot0_q.saturated, slot0_q.active};

	// ---------------- checks ----------------
	`RCR_NEVER(a_cnt_range, out_cnt_q == 2'd3, "output buffer count out of range")
	`RCR_ASSERT(a_sat_active, m_tvalid && m_tuser[1] |-> m_tuser[0], "saturated inactive cell")
	`RCR_ASSERT(a_idle_zero, m_tvalid && !m_tuser[0] |-> m_tdata == 32'd0 && !m_tuser[1],
		"inactive cell with nonzero rate")
	`RCR_ASSERT(a_stall_hold, !pipe_en |=> $stable(vld_s154) && $stable(vld_s23),
		"pipeline moved while stalled")

endmodule

@@ verif/random_coalescence_rate_core_tb.sv @@
// Self-checking testbench for the random-collision coalescence rate core.
`timescale 1ns / 100ps

module random_coalescence_rate_core_tb;
	import rcr_pkg::*;

	typedef struct packed {
		logic [23:0] ut;
		logic [31:0] kappa;
		logic [15:0] alpha;
	} cell_t;

	typedef struct {
		logic [31:0] rate;
		logic        active;
		logic        sat;
	} rate_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [3:0]  paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic        pready;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [71:0] s_tdata = '0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [31:0] m_tdata;
	logic [1:0]  m_tuser;

	// Local copy of the coefficient registers.
	logic [23:0] crc_q = '0;
	logic [23:0] cexp_q = '0;
	logic [15:0] amax_q = MAXP_RESET;
	logic [23:0] phi_q = '0;

	cell_t cell_q[$];
	rate_t rate_q[$];
	int    errors = 0;
	int    idle_cycles = 0;
	int    src_gap = 0;
	int    snk_gap = 0;
	bit    apb_busy = 1'b0;

	localparam int LATENCY = 155;
	localparam int WATCHDOG = 20000;

	random_coalescence_rate_core uut (.*);

	always #5 clk = ~clk;

	// Short gaps mostly, an occasional long one.
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55) return 0;
		if (r < 92) return $urandom_range(1, 3);
		return $urandom_range(10, 60);
	endfunction

	function automatic logic [63:0] cube_root(input logic [63:0] x);
		logic [63:0] y;
		logic [63:0] b;
		y = '0;
		for (int s = 60; s >= 0; s -= 3) begin
			y = y << 1;
			b = 64'd3 * y * (y + 64'd1) + 64'd1;
			if ((x >> s) >= b) begin
				x = x - (b << s);
				y = y + 64'd1;
			end
		end
		return y;
	endfunction

	// floor(a*b >> sh), all ones when it exceeds 64 bits
	function automatic logic [63:0] scaled_mul(input logic [63:0] a, input logic [63:0] b,
			input int sh);
		logic [127:0] p;
		p = ({64'd0, a} * {64'd0, b}) >> sh;
		if (p[127:64] != 0) return '1;
		return p[63:0];
	endfunction

	function automatic logic [63:0] mul_rnd(input logic [63:0] a, input logic [63:0] b);
		logic [127:0] p;
		p = {64'd0, a} * {64'd0, b} + 128'h8000_0000;
		return p[95:32];
	endfunction

	function automatic logic [63:0] decay(input logic [63:0] t);
		logic [63:0] y, q;
		if (t >= (64'd32 << 16)) return '0;
		y = t << 6;
		q = 64'h1_0000_0000 - (y >> 2);
		q = 64'h1_0000_0000 - mul_rnd(y, q) / 64'd3;
		q = 64'h1_0000_0000 - (mul_rnd(y, q) >> 1);
		q = 64'h1_0000_0000 - mul_rnd(y, q);
		if (q > 64'hFFFF_FFFF) q = 64'hFFFF_FFFF;
		for (int i = 0; i < 10; i++) q = mul_rnd(q, q);
		return q;
	endfunction

	function automatic rate_t coalescence(input cell_t c);
		rate_t       o;
		logic [63:0] ca, cm, cam, d, t, f, h, v, r;
		o.rate = '0;
		o.active = 1'b0;
		o.sat = 1'b0;
		if (c.kappa == 0 || c.alpha >= amax_q) return o;
		o.active = 1'b1;
		ca = cube_root(64'(c.alpha) << 44);
		cm = cube_root(64'(amax_q) << 44);
		cam = cube_root((64'(c.alpha) * 64'(amax_q)) << 28);
		d = cm - ca;
		if (d == 0) d = 64'd1;
		t = (64'(cexp_q) * cam) / d;
		f = 64'h1_0000_0000 - decay(t);
		h = (f << 24) / (cm * d);
		v = 64'd12 * 64'(phi_q) * 64'(c.alpha);
		v = scaled_mul(v, 64'(crc_q), 16);
		v = scaled_mul(v, 64'(c.ut), 16);
		v = scaled_mul(v, 64'(c.kappa), 32);
		r = scaled_mul(v, h, 24);
		if (r > 64'hFFFF_FFFF) begin
			o.rate = '1;
			o.sat = 1'b1;
		end else begin
			o.rate = r[31:0];
		end
		return o;
	endfunction

	// Source side: pull from the pending queue, predict on acceptance.
	always @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			rate_q.push_back(coalescence(cell_t'(s_tdata)));
		end
		if (!s_tvalid || s_tready) begin
			if (src_gap > 0) begin
				src_gap <= src_gap - 1;
				s_tvalid <= 1'b0;
			end else if (cell_q.size() > 0 && arst_n) begin
				s_tdata <= cell_q.pop_front();
				s_tvalid <= 1'b1;
				src_gap <= pick_gap();
			end else begin
				s_tvalid <= 1'b0;
			end
		end
	end

	// Sink side: random backpressure, compare against oldest prediction.
	always @(posedge clk) begin
		rate_t e;
		if (m_tvalid && m_tready) begin
			if (rate_q.size() == 0) begin
				$display("%0t: unexpected result rate=%h flags=%b", $time, m_tdata, m_tuser);
				errors++;
			end else begin
				e = rate_q.pop_front();
				if (m_tdata !== e.rate) begin
					$display("%0t: coal_rate expected %h actual %h", $time, e.rate, m_tdata);
					errors++;
				end
				if (m_tuser[0] !== e.active) begin
					$display("%0t: active expected %b actual %b", $time, e.active, m_tuser[0]);
					errors++;
				end
				if (m_tuser[1] !== e.sat) begin
					$display("%0t: saturated expected %b actual %b", $time, e.sat, m_tuser[1]);
					errors++;
				end
			end
		end
		if (snk_gap > 0) begin
			snk_gap <= snk_gap - 1;
			m_tready <= 1'b0;
		end else begin
			m_tready <= 1'b1;
			if ($urandom_range(0, 3) == 0) snk_gap <= pick_gap();
		end
	end

	// Watchdog on cycles with no handshake at all.
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || apb_busy
				|| (cell_q.size() == 0 && rate_q.size() == 0 && !s_tvalid))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG) begin
			$display("random_coalescence_rate_core_tb: done, errors");
			$finish;
		end
	end

	// APB write in setup and access phases; model copy updated at the same edge as the register write.
	task automatic reg_write(input logic [1:0] idx, input logic [31:0] val);
		apb_busy = 1'b1;
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= val;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		case (idx)
			REG_COLL:  crc_q = val[23:0];
			REG_EXPC:  cexp_q = val[23:0];
			REG_MAXP:  amax_q = val[15:0];
			REG_SHAPE: phi_q = val[23:0];
			default: ;
		endcase
		apb_busy = 1'b0;
	endtask

	task automatic settings(input logic [23:0] crc, input logic [23:0] ce,
			input logic [15:0] am, input logic [23:0] phi);
		reg_write(REG_COLL, {8'd0, crc});
		reg_write(REG_EXPC, {8'd0, ce});
		reg_write(REG_MAXP, {16'd0, am});
		reg_write(REG_SHAPE, {8'd0, phi});
	endtask

	// Let the pipeline drain completely before touching registers.
	task automatic drain();
		while (cell_q.size() > 0 || s_tvalid || rate_q.size() > 0) @(posedge clk);
		repeat (LATENCY + 10) @(posedge clk);
	endtask

	function automatic cell_t rand_cell(input logic [15:0] am);
		cell_t c;
		int    r;
		r = $urandom_range(0, 9);
		if (r == 0) c.alpha = 16'($urandom_range(0, 65535));
		else if (r == 1 && am > 0) c.alpha = am - 16'd1;
		else if (r == 2) c.alpha = am;
		else c.alpha = (am > 1) ? 16'($urandom_range(0, 32'(am) - 32'd1)) : 16'd0;
		c.kappa = ($urandom_range(0, 19) == 0) ? 32'd0 : 32'($urandom);
		if ($urandom_range(0, 2) == 0) c.kappa = c.kappa >> $urandom_range(0, 31);
		c.ut = 24'($urandom_range(0, 24'hFFFFFF));
		if ($urandom_range(0, 2) == 0) c.ut = c.ut >> $urandom_range(0, 23);
		return c;
	endfunction

	task automatic random_phase(input int n);
		for (int i = 0; i < n; i++) cell_q.push_back(rand_cell(amax_q));
		drain();
	endtask

	initial begin
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: reset values first (every cell gives zero rate).
		cell_q.push_back('{24'hFFFFFF, 32'hFFFFFFFF, 16'd0});
		cell_q.push_back('{24'd0, 32'd0, 16'd100});
		drain();
		settings(24'h010000, 24'h010000, 16'hC000, 24'h400000);
		cell_q.push_back('{24'h010000, 32'h00000100, 16'd0});
		cell_q.push_back('{24'h010000, 32'h00000100, 16'h8000});
		cell_q.push_back('{24'h010000, 32'h00000100, 16'hBFFF});
		cell_q.push_back('{24'h010000, 32'h00000100, 16'hC000});
		cell_q.push_back('{24'h010000, 32'h00000100, 16'hFFFF});
		cell_q.push_back('{24'h010000, 32'h00000000, 16'h4000});
		cell_q.push_back('{24'hFFFFFF, 32'hFFFFFFFF, 16'h2000});
		cell_q.push_back('{24'd0, 32'hFFFFFFFF, 16'h2000});
		cell_q.push_back('{24'd1, 32'd1, 16'd1});
		drain();
		// Extremes: everything maxed (saturation), then zero max packing, then max packing of one.
		settings('1, '1, 16'hFFFF, '1);
		cell_q.push_back('{24'hFFFFFF, 32'hFFFFFFFF, 16'hFFFE});
		cell_q.push_back('{24'hFFFFFF, 32'hFFFFFFFF, 16'h0001});
		cell_q.push_back('{24'h000100, 32'h00001000, 16'h8000});
		drain();
		settings('1, 24'd0, 16'd0, '1);
		cell_q.push_back('{24'hFFFFFF, 32'hFFFFFFFF, 16'd0});
		cell_q.push_back('{24'h123456, 32'h00000001, 16'hFFFF});
		drain();
		settings(24'd0, '1, 16'd1, 24'd1);
		cell_q.push_back('{24'hFFFFFF, 32'hFFFFFFFF, 16'd0});
		drain();

		// Random phases over a sweep of settings.
		for (int p = 0; p < 8; p++) begin
			settings(24'($urandom_range(0, 24'hFFFFFF) >> $urandom_range(0, 12)),
				24'($urandom_range(0, 24'hFFFFFF) >> $urandom_range(4, 20)),
				(p == 3) ? 16'hFFFF : (p == 5) ? 16'd1 : 16'($urandom_range(1, 65535)),
				24'($urandom_range(0, 24'hFFFFFF)));
			random_phase(210);
		end

		if (errors == 0)
			$display("random_coalescence_rate_core_tb: done, clean");
		else
			$display("random_coalescence_rate_core_tb: done, errors");
		$finish;
	end

endmodule

@@ filelist.f @@
+incdir+sv
sv/rcr_pkg.sv
sv/rcr_cbrt.sv
sv/rcr_div.sv
sv/rcr_exp.sv
sv/rcr_gain.sv
sv/random_coalescence_rate_core.sv
verif/random_coalescence_rate_core_tb.sv
